>>> rtl/refcounted_palette_slot_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the palette slot table checks
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_PALETTE_SLOT_TABLE_ASSERT_SVH
`define REFCOUNTED_PALETTE_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication
`define RPST_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpst assertion failed");

// Next-cycle implication
`define RPST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpst assertion failed");

`endif

>>> rtl/rpst_pkg.sv
// ----------------------------------------------------------------------------
// rpst_pkg
// Types, codes and helpers shared by the palette slot table modules.
// ----------------------------------------------------------------------------
package rpst_pkg;

    localparam int ACT_W  = 2;
    localparam int TYPE_W = 3;
    localparam int TAG_W  = 16;
    localparam int CNT_W  = 8;
    localparam int SLOT_W = 4;

    localparam logic [ACT_W-1:0] ACT_ACQUIRE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd2;

    localparam logic [TYPE_W-1:0] TYPE_FREE = 3'd0;
    localparam logic [CNT_W-1:0]  COUNT_MAX = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_APPLY,
        ST_RELEASE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [TYPE_W-1:0] etype;
        logic [TAG_W-1:0]  tag;
        logic [CNT_W-1:0]  count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic start;    // new item: reset the tracking
        logic step;     // an entry is presented this cycle
        logic at_zero;  // the presented entry is slot 0
    } scan_ctl_t;

    typedef struct packed {
        logic   hit;
        logic   free_found;
        entry_t hit_entry;
        entry_t zero_entry;
    } scan_stat_t;

    function automatic logic [CNT_W-1:0] count_inc(input logic [CNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : CNT_W'(c + 1'b1);
    endfunction

    function automatic logic [CNT_W-1:0] count_dec(input logic [CNT_W-1:0] c);
        return (c == '0) ? c : CNT_W'(c - 1'b1);
    endfunction

endpackage

>>> rtl/rpst_ram.sv
// ----------------------------------------------------------------------------
// rpst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpst_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rpst_scan.sv
// ----------------------------------------------------------------------------
// rpst_scan
// Shared compare unit: checks one entry a cycle against the item's type and
// tag, keeps the first match, the first free slot and the slot 0 entry.
// ----------------------------------------------------------------------------
module rpst_scan #(
    parameter int IDX_W = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rpst_pkg::scan_ctl_t               ctl,
    input  logic [IDX_W-1:0]                  idx,
    input  rpst_pkg::entry_t                  entry,
    input  logic [rpst_pkg::TYPE_W-1:0]       ref_type,
    input  logic [rpst_pkg::TAG_W-1:0]        ref_tag,
    output rpst_pkg::scan_stat_t              stat,
    output logic [IDX_W-1:0]                  hit_idx,
    output logic [IDX_W-1:0]                  free_idx
);

    logic             hit_reg;
    logic             hit_next;
    logic             free_reg;
    logic             free_next;
    logic             match;
    logic             is_free;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] free_idx_reg;
    rpst_pkg::entry_t hit_entry_reg;
    rpst_pkg::entry_t zero_entry_reg;

    assign match   = (entry.etype == ref_type) && (entry.tag == ref_tag);
    assign is_free = (entry.etype == rpst_pkg::TYPE_FREE);

    always_comb
    begin
        hit_next  = hit_reg;
        free_next = free_reg;
        if (ctl.start)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        else if (ctl.step)
        begin
            if (match)
            begin
                hit_next = 1'b1;
            end
            if (is_free)
            begin
                free_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            hit_reg  <= hit_next;
            free_reg <= free_next;
        end
    end

    // keep only the lowest matching / free slot
    always_ff @(posedge clk)
    begin
        if (ctl.step && !ctl.start)
        begin
            if (match && !hit_reg)
            begin
                hit_idx_reg   <= idx;
                hit_entry_reg <= entry;
            end
            if (is_free && !free_reg)
            begin
                free_idx_reg <= idx;
            end
            if (ctl.at_zero)
            begin
                zero_entry_reg <= entry;
            end
        end
    end

    assign stat.hit        = hit_reg;
    assign stat.free_found = free_reg;
    assign stat.hit_entry  = hit_entry_reg;
    assign stat.zero_entry = zero_entry_reg;
    assign hit_idx         = hit_idx_reg;
    assign free_idx        = free_idx_reg;

endmodule

>>> rtl/refcounted_palette_slot_table.sv
// ----------------------------------------------------------------------------
// refcounted_palette_slot_table
// Reference-counted table of palette slots: acquire, release and clear.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid / in_ready  | action, ref_type, ref_tag,
//          |           |                      | release_slot
//  out     | output    | out_valid / out_ready| slot, was_found, newly_claimed,
//          |           |                      | failed, use_count
//  cfg     | input     | cfg_valid / cfg_ready| full_fallback
//
//  Flow: an acquire scans every slot through the one RAM read port and the shared
//  compare unit, then passes the drain and apply states; a release passes the release
//  state; clear, reserved type, out-of-range releases and unused actions go straight
//  to done. in_ready returns with out_valid. One item is in work at a time.
//  Stalls: a result left waiting on out_ready holds the next one in the done state,
//  and in_ready stays low until it moves. cfg_ready is always high.
//  Reset: per-slot valid bits clear, so every slot reads unused; fallback comes up 1.
// ----------------------------------------------------------------------------
module refcounted_palette_slot_table #(
    parameter int SLOTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rpst_pkg::ACT_W-1:0]        action,
    input  logic [rpst_pkg::TYPE_W-1:0]       ref_type,
    input  logic [rpst_pkg::TAG_W-1:0]        ref_tag,
    input  logic [rpst_pkg::SLOT_W-1:0]       release_slot,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rpst_pkg::SLOT_W-1:0]       slot,
    output logic                              was_found,
    output logic                              newly_claimed,
    output logic                              failed,
    output logic [rpst_pkg::CNT_W-1:0]        use_count,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              full_fallback
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int PAD_N = 1 << IDX_W;
    localparam int CMP_W = ((IDX_W > rpst_pkg::SLOT_W) ? IDX_W : rpst_pkg::SLOT_W) + 1;

    // sequencer
    rpst_pkg::state_t state_reg;
    rpst_pkg::state_t state_next;

    // configuration
    logic full_fallback_reg;

    // per-slot valid bits; an invalid slot reads as all zero
    logic [SLOTS-1:0] valid_reg;
    logic [PAD_N-1:0] valid_pad;

    // scan and read pipeline
    logic [IDX_W-1:0] scan_addr_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_valid_reg;
    logic             step_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [rpst_pkg::ENTRY_W-1:0] ram_rdata;
    rpst_pkg::entry_t rd_entry;

    // write port
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rpst_pkg::entry_t wr_entry;

    // latched item
    logic [rpst_pkg::TYPE_W-1:0] type_reg;
    logic [rpst_pkg::TAG_W-1:0]  tag_reg;
    logic [rpst_pkg::SLOT_W-1:0] rel_reg;

    // result staging
    logic                         res_load;
    logic [rpst_pkg::SLOT_W-1:0]  res_slot_reg;
    logic [rpst_pkg::SLOT_W-1:0]  res_slot_next;
    logic                         res_found_reg;
    logic                         res_found_next;
    logic                         res_new_reg;
    logic                         res_new_next;
    logic                         res_fail_reg;
    logic                         res_fail_next;
    logic [rpst_pkg::CNT_W-1:0]   res_count_reg;
    logic [rpst_pkg::CNT_W-1:0]   res_count_next;

    // output register
    logic                         out_valid_reg;
    logic                         out_load;
    logic [rpst_pkg::SLOT_W-1:0]  out_slot_reg;
    logic                         out_found_reg;
    logic                         out_new_reg;
    logic                         out_fail_reg;
    logic [rpst_pkg::CNT_W-1:0]   out_count_reg;

    // scan unit
    rpst_pkg::scan_ctl_t  scan_ctl;
    rpst_pkg::scan_stat_t scan_stat;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     free_idx;

    // misc decode
    logic                         accept;
    logic                         rel_in_range;
    logic [rpst_pkg::CNT_W-1:0]   inc_base;
    logic [rpst_pkg::CNT_W-1:0]   inc_count;
    logic [rpst_pkg::CNT_W-1:0]   dec_count;
    logic                         clear_all;

    assign accept       = in_valid && in_ready;
    assign rel_in_range = CMP_W'(release_slot) < CMP_W'(SLOTS);
    assign valid_pad    = PAD_N'(valid_reg);
    assign rd_entry     = rd_valid_reg ? rpst_pkg::entry_t'(ram_rdata) : '0;
    assign cfg_ready    = 1'b1;

    // ------------------------------------------------------------------
    // storage and compare unit
    // ------------------------------------------------------------------
    rpst_ram #(
        .WIDTH (rpst_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign scan_ctl.start   = accept;
    assign scan_ctl.step    = step_reg;
    assign scan_ctl.at_zero = (rd_idx_reg == '0);

    rpst_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .idx      (rd_idx_reg),
        .entry    (rd_entry),
        .ref_type (type_reg),
        .ref_tag  (tag_reg),
        .stat     (scan_stat),
        .hit_idx  (hit_idx),
        .free_idx (free_idx)
    );

    // one saturating increment shared by hit, claim and fallback
    always_comb
    begin
        if (scan_stat.hit)
        begin
            inc_base = scan_stat.hit_entry.count;
        end
        else if (scan_stat.free_found)
        begin
            inc_base = '0;
        end
        else
        begin
            inc_base = scan_stat.zero_entry.count;
        end
    end

    assign inc_count = rpst_pkg::count_inc(inc_base);
    assign dec_count = rpst_pkg::count_dec(rd_entry.count);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rpst_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == rpst_pkg::ACT_ACQUIRE && ref_type != rpst_pkg::TYPE_FREE)
                    begin
                        state_next = rpst_pkg::ST_SCAN;
                    end
                    else if (action == rpst_pkg::ACT_RELEASE && rel_in_range)
                    begin
                        state_next = rpst_pkg::ST_RELEASE;
                    end
                    else
                    begin
                        state_next = rpst_pkg::ST_DONE;
                    end
                end
            end
            rpst_pkg::ST_SCAN:
            begin
                if (scan_addr_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = rpst_pkg::ST_DRAIN;
                end
            end
            rpst_pkg::ST_DRAIN:   state_next = rpst_pkg::ST_APPLY;
            rpst_pkg::ST_APPLY:   state_next = rpst_pkg::ST_DONE;
            rpst_pkg::ST_RELEASE: state_next = rpst_pkg::ST_DONE;
            rpst_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = rpst_pkg::ST_IDLE;
                end
            end
            default:              state_next = rpst_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // state outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready       = 1'b0;
        rd_addr        = scan_addr_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_entry       = '0;
        clear_all      = 1'b0;
        out_load       = 1'b0;
        res_load       = 1'b0;
        res_slot_next  = '0;
        res_found_next = 1'b0;
        res_new_next   = 1'b0;
        res_fail_next  = 1'b0;
        res_count_next = '0;
        case (state_reg)
            rpst_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                // read the release target right away
                rd_addr  = IDX_W'(release_slot);
                if (in_valid)
                begin
                    res_load = 1'b1;
                    case (action)
                        rpst_pkg::ACT_ACQUIRE:
                        begin
                            // reserved type fails; a real acquire is overwritten later
                            res_fail_next = 1'b1;
                        end
                        rpst_pkg::ACT_RELEASE:
                        begin
                            res_slot_next = release_slot;
                        end
                        rpst_pkg::ACT_CLEAR:
                        begin
                            clear_all = 1'b1;
                        end
                        default:
                        begin
                            res_slot_next = '0;
                        end
                    endcase
                end
            end
            rpst_pkg::ST_APPLY:
            begin
                res_load = 1'b1;
                if (scan_stat.hit)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = hit_idx;
                    wr_entry       = scan_stat.hit_entry;
                    wr_entry.count = inc_count;
                    res_slot_next  = rpst_pkg::SLOT_W'(hit_idx);
                    res_found_next = 1'b1;
                    res_count_next = inc_count;
                end
                else if (scan_stat.free_found)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = free_idx;
                    wr_entry.etype = type_reg;
                    wr_entry.tag   = tag_reg;
                    wr_entry.count = inc_count;
                    res_slot_next  = rpst_pkg::SLOT_W'(free_idx);
                    res_new_next   = 1'b1;
                    res_count_next = inc_count;
                end
                else if (full_fallback_reg)
                begin
                    // table full: charge slot 0
                    wr_en          = 1'b1;
                    wr_addr        = '0;
                    wr_entry       = scan_stat.zero_entry;
                    wr_entry.count = inc_count;
                    res_count_next = inc_count;
                end
                else
                begin
                    res_fail_next = 1'b1;
                end
            end
            rpst_pkg::ST_RELEASE:
            begin
                res_load       = 1'b1;
                wr_en          = 1'b1;
                wr_addr        = IDX_W'(rel_reg);
                // a count that reaches zero frees the slot
                if (dec_count != '0)
                begin
                    wr_entry       = rd_entry;
                    wr_entry.count = dec_count;
                end
                res_slot_next  = rel_reg;
                res_count_next = dec_count;
            end
            rpst_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                rd_addr = scan_addr_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= rpst_pkg::ST_IDLE;
            full_fallback_reg <= 1'b1;
            valid_reg         <= '0;
            step_reg          <= 1'b0;
            rd_valid_reg      <= 1'b0;
            scan_addr_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= (state_reg == rpst_pkg::ST_SCAN);
            rd_valid_reg <= valid_pad[rd_addr];

            if (cfg_valid && cfg_ready)
            begin
                full_fallback_reg <= full_fallback;
            end

            // advance the scan address, restart on each new item
            if (accept)
            begin
                scan_addr_reg <= '0;
            end
            else if (state_reg == rpst_pkg::ST_SCAN)
            begin
                scan_addr_reg <= IDX_W'(scan_addr_reg + 1'b1);
            end

            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_addr;

        if (accept)
        begin
            type_reg <= ref_type;
            tag_reg  <= ref_tag;
            rel_reg  <= release_slot;
        end

        if (res_load)
        begin
            res_slot_reg  <= res_slot_next;
            res_found_reg <= res_found_next;
            res_new_reg   <= res_new_next;
            res_fail_reg  <= res_fail_next;
            res_count_reg <= res_count_next;
        end

        if (out_load)
        begin
            out_slot_reg  <= res_slot_reg;
            out_found_reg <= res_found_reg;
            out_new_reg   <= res_new_reg;
            out_fail_reg  <= res_fail_reg;
            out_count_reg <= res_count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign slot          = out_slot_reg;
    assign was_found     = out_found_reg;
    assign newly_claimed = out_new_reg;
    assign failed        = out_fail_reg;
    assign use_count     = out_count_reg;

endmodule

>>> rtl/rpst_checker.sv
// ----------------------------------------------------------------------------
// rpst_checker
// Port-level checks on the palette slot table, bound to the top level.
// ----------------------------------------------------------------------------
`include "refcounted_palette_slot_table_assert.svh"

module rpst_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [rpst_pkg::SLOT_W-1:0] slot,
    input logic                        was_found,
    input logic                        newly_claimed,
    input logic                        failed,
    input logic [rpst_pkg::CNT_W-1:0]  use_count
);

    // at most one outcome flag per result
    `RPST_ASSERT_IMP(a_one_outcome, out_valid,
        !(was_found && newly_claimed) && !(failed && (was_found || newly_claimed)))

    // a failed acquire reports slot 0 with a zero count
    `RPST_ASSERT_IMP(a_fail_zero, out_valid && failed, use_count == '0 && slot == '0)

    // a fresh claim starts at one, a match never reports zero
    `RPST_ASSERT_IMP(a_count_claim, out_valid && (newly_claimed || was_found),
        use_count != '0 && (!newly_claimed || use_count == 8'd1))

    // one item at a time: no accept right after an accept
    `RPST_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

    // a stalled result holds
    `RPST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(slot) && $stable(use_count) && $stable(failed))

endmodule

bind refcounted_palette_slot_table rpst_checker u_rpst_checker (.*);
